FILE: rtl/i2c_mbs_pkg.sv
`default_nettype none

package i2c_mbs_pkg;

    // bits clocked per byte, data and receive
    localparam int          BITS_PER_BYTE = 8;
    localparam int          BIT_CNT_W     = 4;
    localparam logic [BIT_CNT_W-1:0] BYTE_BITS = BIT_CNT_W'(BITS_PER_BYTE);

    // command codes carried by a tick
    typedef enum logic [2:0] {
        CMD_NONE       = 3'd0,
        CMD_START      = 3'd1,
        CMD_STOP       = 3'd2,
        CMD_SEND_DATA  = 3'd3,
        CMD_ADDR_WRITE = 3'd4,
        CMD_ADDR_READ  = 3'd5,
        CMD_RECV_ACK   = 3'd6,
        CMD_RECV_NACK  = 3'd7
    } cmd_t;

    // sequence in progress
    typedef enum logic [2:0] {
        OP_IDLE      = 3'd0,
        OP_START     = 3'd1,
        OP_STOP      = 3'd2,
        OP_SEND      = 3'd3,
        OP_RECV_ACK  = 3'd4,
        OP_RECV_NACK = 3'd5
    } op_t;

    // pin phase within a sequence
    typedef logic [2:0] phase_t;
    localparam phase_t PH_0 = 3'd0;
    localparam phase_t PH_1 = 3'd1;
    localparam phase_t PH_2 = 3'd2;
    localparam phase_t PH_3 = 3'd3;
    localparam phase_t PH_4 = 3'd4;
    localparam phase_t PH_5 = 3'd5;
    localparam phase_t PH_6 = 3'd6;

    typedef struct packed {
        cmd_t       cmd;
        logic [7:0] data_byte;
        logic [6:0] device_address;
        logic       sda_in;
    } in_item_t;

    typedef struct packed {
        logic       scl_out;
        logic       sda_out;
        logic       sda_drive;
        logic       busy_res;
        logic       done_res;
        logic       rx_valid;
        logic [7:0] rx_data;
    } out_item_t;

endpackage

`default_nettype wire

FILE: rtl/i2c_master_bit_sequencer.sv
// a result item sits in a single output register, valid in the cycle after
// its tick item is accepted; the pin sequencer state advances at the accepting
// edge; throughput: one tick per cycle unless a full output waits on m_ready
// reset: synchronous active-low aresetn clears the output valid, sets the
// sequencer idle with scl and sda high and sda driven
`default_nettype none

module i2c_master_bit_sequencer
    import i2c_mbs_pkg::*;
(
    input  wire logic      aclk,
    input  wire logic      aresetn,
    input  wire logic      s_valid,
    output logic           s_ready,
    input  wire in_item_t  s_item,
    output logic           m_valid,
    input  wire logic      m_ready,
    output out_item_t      m_item
);

    // sequencer state
    op_t                  op_reg, op_next;
    phase_t               phase_reg, phase_next;
    logic [BIT_CNT_W-1:0] bit_cnt_reg, bit_cnt_next;
    logic [7:0]           shift_reg, shift_next;
    logic                 scl_reg, scl_next;
    logic                 sda_reg, sda_next;
    logic                 dir_reg, dir_next;

    // output stage
    logic                 m_valid_reg;
    out_item_t            m_item_reg;

    logic                 accept;
    logic                 done;
    logic                 rx_v;
    logic [7:0]           rx_d;

    // the output register takes a new item when empty or being drained
    assign s_ready = !m_valid_reg || m_ready;
    assign accept  = s_valid && s_ready;
    assign m_valid = m_valid_reg;
    assign m_item  = m_item_reg;

    // state register, advances only on an accepted tick
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            op_reg      <= OP_IDLE;
            phase_reg   <= PH_0;
            bit_cnt_reg <= '0;
            shift_reg   <= '0;
            scl_reg     <= 1'b1;
            sda_reg     <= 1'b1;
            dir_reg     <= 1'b1;
        end else if (accept) begin
            op_reg      <= op_next;
            phase_reg   <= phase_next;
            bit_cnt_reg <= bit_cnt_next;
            shift_reg   <= shift_next;
            scl_reg     <= scl_next;
            sda_reg     <= sda_next;
            dir_reg     <= dir_next;
        end
    end

    // next state and pin levels for this tick
    always_comb begin
        op_next      = op_reg;
        phase_next   = phase_reg;
        bit_cnt_next = bit_cnt_reg;
        shift_next   = shift_reg;
        scl_next     = scl_reg;
        sda_next     = sda_reg;
        dir_next     = dir_reg;
        done         = 1'b0;
        rx_v         = 1'b0;
        rx_d         = 8'h00;

        // command launch, first phase runs on the same tick
        if (op_reg == OP_IDLE && s_item.cmd != CMD_NONE) begin
            phase_next   = PH_0;
            bit_cnt_next = '0;
            unique case (s_item.cmd)
                CMD_START: op_next = OP_START;
                CMD_STOP:  op_next = OP_STOP;
                CMD_SEND_DATA: begin
                    op_next    = OP_SEND;
                    shift_next = s_item.data_byte;
                end
                CMD_ADDR_WRITE: begin
                    op_next    = OP_SEND;
                    shift_next = {s_item.device_address, 1'b0};
                end
                CMD_ADDR_READ: begin
                    op_next    = OP_SEND;
                    shift_next = {s_item.device_address, 1'b1};
                end
                CMD_RECV_ACK:  op_next = OP_RECV_ACK;
                default:       op_next = OP_RECV_NACK;
            endcase
        end

        unique case (op_next) inside
            OP_START: begin
                if (phase_next == PH_0) begin
                    sda_next   = 1'b1;
                    phase_next = PH_1;
                end else if (phase_next == PH_1) begin
                    scl_next   = 1'b1;
                    phase_next = PH_2;
                end else if (phase_next == PH_2) begin
                    sda_next   = 1'b0;
                    phase_next = PH_3;
                end else begin
                    scl_next   = 1'b0;
                    done       = 1'b1;
                    op_next    = OP_IDLE;
                    phase_next = PH_0;
                end
            end
            OP_STOP: begin
                if (phase_next == PH_0) begin
                    scl_next   = 1'b0;
                    phase_next = PH_1;
                end else if (phase_next == PH_1) begin
                    sda_next   = 1'b0;
                    phase_next = PH_2;
                end else if (phase_next == PH_2) begin
                    scl_next   = 1'b1;
                    phase_next = PH_3;
                end else begin
                    sda_next   = 1'b1;
                    done       = 1'b1;
                    op_next    = OP_IDLE;
                    phase_next = PH_0;
                end
            end
            OP_SEND: begin
                if (phase_next == PH_0) begin
                    // msb out, shift left
                    sda_next   = shift_next[7];
                    shift_next = {shift_next[6:0], 1'b0};
                    phase_next = PH_1;
                end else if (phase_next == PH_1) begin
                    scl_next   = 1'b1;
                    phase_next = PH_2;
                end else if (phase_next == PH_2) begin
                    scl_next     = 1'b0;
                    bit_cnt_next = bit_cnt_next + 1'b1;
                    phase_next   = (bit_cnt_next >= BYTE_BITS) ? PH_3 : PH_0;
                end else if (phase_next == PH_3) begin
                    // release sda for the slave acknowledge
                    dir_next   = 1'b0;
                    phase_next = PH_4;
                end else if (phase_next == PH_4) begin
                    scl_next   = 1'b1;
                    phase_next = PH_5;
                end else if (phase_next == PH_5) begin
                    // hold scl high until the slave pulls sda low
                    if (!s_item.sda_in) begin
                        scl_next   = 1'b0;
                        phase_next = PH_6;
                    end
                end else begin
                    dir_next   = 1'b1;
                    done       = 1'b1;
                    op_next    = OP_IDLE;
                    phase_next = PH_0;
                end
            end
            OP_RECV_ACK, OP_RECV_NACK: begin
                if (phase_next == PH_0) begin
                    dir_next     = 1'b0;
                    shift_next   = 8'h00;
                    bit_cnt_next = '0;
                    phase_next   = PH_1;
                end else if (phase_next == PH_1) begin
                    // sample sda as scl rises
                    scl_next   = 1'b1;
                    shift_next = {shift_next[6:0], s_item.sda_in};
                    phase_next = PH_2;
                end else if (phase_next == PH_2) begin
                    scl_next     = 1'b0;
                    bit_cnt_next = bit_cnt_next + 1'b1;
                    phase_next   = (bit_cnt_next >= BYTE_BITS) ? PH_3 : PH_1;
                end else if (phase_next == PH_3) begin
                    // ack low, nack high
                    dir_next   = 1'b1;
                    sda_next   = (op_next == OP_RECV_NACK);
                    phase_next = PH_4;
                end else if (phase_next == PH_4) begin
                    scl_next   = 1'b1;
                    phase_next = PH_5;
                end else if (phase_next == PH_5) begin
                    scl_next   = 1'b0;
                    phase_next = PH_6;
                end else begin
                    sda_next   = 1'b1;
                    done       = 1'b1;
                    rx_v       = 1'b1;
                    rx_d       = shift_next;
                    op_next    = OP_IDLE;
                    phase_next = PH_0;
                end
            end
            default: begin
                op_next    = OP_IDLE;
                phase_next = PH_0;
            end
        endcase
    end

    // output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (accept) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            m_item_reg.scl_out   <= scl_next;
            m_item_reg.sda_out   <= sda_next;
            m_item_reg.sda_drive <= dir_next;
            m_item_reg.busy_res  <= (op_next != OP_IDLE);
            m_item_reg.done_res  <= done;
            m_item_reg.rx_valid  <= rx_v;
            m_item_reg.rx_data   <= rx_d;
        end
    end

    // a completed sequence always leaves the sequencer idle
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_item.done_res) |-> !m_item.busy_res)
        else $error("done reported while still busy");

    // received byte only on a completing tick
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_item.rx_valid) |-> m_item.done_res)
        else $error("rx_valid without done");

    // rx_data is zero unless a byte is delivered
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_item.rx_valid) |-> (m_item.rx_data == 8'h00))
        else $error("rx_data set without rx_valid");

    // idle always sits at the first phase
    assert property (@(posedge aclk) disable iff (!aresetn)
        (op_reg == OP_IDLE) |-> (phase_reg == PH_0))
        else $error("idle with nonzero phase");

endmodule

`default_nettype wire

FILE: dv/i2c_pin_checker.sv
module i2c_pin_checker
    import i2c_mbs_pkg::*;
(
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      s_valid,
    input  logic      s_ready,
    input  in_item_t  s_item,
    input  logic      m_valid,
    input  logic      m_ready,
    input  out_item_t m_item,
    output int        mismatches,
    output int        waiting
);

    // own copy of the sequencer state
    op_t        cur_op;
    phase_t     cur_phase;
    logic [3:0] bits_done;
    logic [7:0] shifter;
    logic       scl_q;
    logic       sda_q;
    logic       drive_q;

    out_item_t  expected_pins[$];

    function automatic void to_idle();
        cur_op    = OP_IDLE;
        cur_phase = PH_0;
    endfunction

    // one bus tick: latch a command when idle, then run one pin phase
    function automatic out_item_t advance_pins(input in_item_t tk);
        out_item_t  r;
        logic       finished;
        logic       got_byte;
        logic [7:0] got_data;
        finished = 1'b0;
        got_byte = 1'b0;
        got_data = '0;
        if (cur_op == OP_IDLE && tk.cmd != CMD_NONE) begin
            cur_phase = PH_0;
            bits_done = '0;
            case (tk.cmd)
                CMD_START:      cur_op = OP_START;
                CMD_STOP:       cur_op = OP_STOP;
                CMD_SEND_DATA: begin
                    cur_op  = OP_SEND;
                    shifter = tk.data_byte;
                end
                CMD_ADDR_WRITE: begin
                    cur_op  = OP_SEND;
                    shifter = {tk.device_address, 1'b0};
                end
                CMD_ADDR_READ: begin
                    cur_op  = OP_SEND;
                    shifter = {tk.device_address, 1'b1};
                end
                CMD_RECV_ACK:   cur_op = OP_RECV_ACK;
                default:        cur_op = OP_RECV_NACK;
            endcase
        end
        case (cur_op) inside
            OP_START: begin
                case (cur_phase)
                    PH_0: begin sda_q = 1'b1; cur_phase = PH_1; end
                    PH_1: begin scl_q = 1'b1; cur_phase = PH_2; end
                    PH_2: begin sda_q = 1'b0; cur_phase = PH_3; end
                    default: begin
                        scl_q    = 1'b0;
                        finished = 1'b1;
                        to_idle();
                    end
                endcase
            end
            OP_STOP: begin
                case (cur_phase)
                    PH_0: begin scl_q = 1'b0; cur_phase = PH_1; end
                    PH_1: begin sda_q = 1'b0; cur_phase = PH_2; end
                    PH_2: begin scl_q = 1'b1; cur_phase = PH_3; end
                    default: begin
                        sda_q    = 1'b1;
                        finished = 1'b1;
                        to_idle();
                    end
                endcase
            end
            OP_SEND: begin
                case (cur_phase)
                    PH_0: begin
                        sda_q     = shifter[7];
                        shifter   = {shifter[6:0], 1'b0};
                        cur_phase = PH_1;
                    end
                    PH_1: begin scl_q = 1'b1; cur_phase = PH_2; end
                    PH_2: begin
                        scl_q     = 1'b0;
                        bits_done = bits_done + 4'd1;
                        cur_phase = (bits_done >= BYTE_BITS) ? PH_3 : PH_0;
                    end
                    PH_3: begin drive_q = 1'b0; cur_phase = PH_4; end
                    PH_4: begin scl_q = 1'b1; cur_phase = PH_5; end
                    PH_5: begin
                        // slave acknowledge, no timeout
                        if (!tk.sda_in) begin
                            scl_q     = 1'b0;
                            cur_phase = PH_6;
                        end
                    end
                    default: begin
                        drive_q  = 1'b1;
                        finished = 1'b1;
                        to_idle();
                    end
                endcase
            end
            OP_RECV_ACK, OP_RECV_NACK: begin
                case (cur_phase)
                    PH_0: begin
                        drive_q   = 1'b0;
                        shifter   = '0;
                        bits_done = '0;
                        cur_phase = PH_1;
                    end
                    PH_1: begin
                        scl_q     = 1'b1;
                        shifter   = {shifter[6:0], tk.sda_in};
                        cur_phase = PH_2;
                    end
                    PH_2: begin
                        scl_q     = 1'b0;
                        bits_done = bits_done + 4'd1;
                        cur_phase = (bits_done >= BYTE_BITS) ? PH_3 : PH_1;
                    end
                    PH_3: begin
                        drive_q   = 1'b1;
                        sda_q     = (cur_op == OP_RECV_NACK);
                        cur_phase = PH_4;
                    end
                    PH_4: begin scl_q = 1'b1; cur_phase = PH_5; end
                    PH_5: begin scl_q = 1'b0; cur_phase = PH_6; end
                    default: begin
                        sda_q    = 1'b1;
                        finished = 1'b1;
                        got_byte = 1'b1;
                        got_data = shifter;
                        to_idle();
                    end
                endcase
            end
            default: to_idle();
        endcase
        r.scl_out   = scl_q;
        r.sda_out   = sda_q;
        r.sda_drive = drive_q;
        r.busy_res  = (cur_op != OP_IDLE);
        r.done_res  = finished;
        r.rx_valid  = got_byte;
        r.rx_data   = got_data;
        return r;
    endfunction

    task automatic check_field(input string name, input logic [7:0] want,
                               input logic [7:0] got);
        if (got !== want) begin
            $error("%s: expected %0h, got %0h", name, want, got);
            mismatches++;
        end
    endtask

    always @(posedge aclk) begin
        out_item_t want;
        if (!aresetn) begin
            cur_op    = OP_IDLE;
            cur_phase = PH_0;
            bits_done = '0;
            shifter   = '0;
            scl_q     = 1'b1;
            sda_q     = 1'b1;
            drive_q   = 1'b1;
            expected_pins.delete();
        end else begin
            if (s_valid && s_ready)
                expected_pins.push_back(advance_pins(s_item));
            if (m_valid && m_ready) begin
                if (expected_pins.size() == 0) begin
                    $error("result item with no tick waiting for it");
                    mismatches++;
                end else begin
                    want = expected_pins.pop_front();
                    check_field("scl_out",   8'(want.scl_out),   8'(m_item.scl_out));
                    check_field("sda_out",   8'(want.sda_out),   8'(m_item.sda_out));
                    check_field("sda_drive", 8'(want.sda_drive), 8'(m_item.sda_drive));
                    check_field("busy_res",  8'(want.busy_res),  8'(m_item.busy_res));
                    check_field("done_res",  8'(want.done_res),  8'(m_item.done_res));
                    check_field("rx_valid",  8'(want.rx_valid),  8'(m_item.rx_valid));
                    check_field("rx_data",   want.rx_data,       m_item.rx_data);
                end
            end
        end
        waiting = expected_pins.size();
    end

endmodule

FILE: dv/i2c_master_bit_sequencer_tb.sv
module i2c_master_bit_sequencer_tb;
    import i2c_mbs_pkg::*;

    logic      aclk    = 1'b0;
    logic      aresetn = 1'b0;
    logic      s_valid = 1'b0;
    logic      s_ready;
    in_item_t  s_item  = '0;
    logic      m_valid;
    logic      m_ready = 1'b0;
    out_item_t m_item;

    int mismatches;
    int waiting;

    // traffic shaping, shared between the sender and the receiver process
    int send_idle_pct   = 0;
    int drain_stall_pct = 0;
    bit long_hold       = 1'b0;
    int ticks_sent      = 0;

    // idle and stall mix per phase: none, sender idle, receiver stall, both
    int idle_mix[4]  = '{0, 75, 0, 29};
    int stall_mix[4] = '{0, 0, 75, 29};

    i2c_master_bit_sequencer dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_item  (s_item),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_item  (m_item)
    );

    i2c_pin_checker pin_checker (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_item     (s_item),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_item     (m_item),
        .mismatches (mismatches),
        .waiting    (waiting)
    );

    initial begin
        forever #1 aclk = ~aclk;
    end

    // hard stop well beyond the slowest legal run
    initial begin
        #400000;
        $display("Mismatches found");
        $finish;
    end

    // receiver: random back-pressure, plus one long hold-off on request so the
    // output register fills and the block has to stall its input
    initial begin
        forever begin
            @(posedge aclk);
            if (long_hold) begin
                m_ready <= 1'b0;
                repeat (200) @(posedge aclk);
                long_hold = 1'b0;
            end else begin
                m_ready <= ($urandom_range(0, 99) >= drain_stall_pct);
            end
        end
    end

    // byte value with a fair share of the extremes
    function automatic logic [7:0] any_byte();
        case ($urandom_range(0, 5))
            0:       return 8'h00;
            1:       return 8'hFF;
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    // one tick item, data and address fields filled at random
    function automatic in_item_t tick_of(input cmd_t c, input logic sda);
        in_item_t   t;
        logic [7:0] a;
        a                = any_byte();
        t.cmd            = c;
        t.data_byte      = any_byte();
        t.device_address = a[7:1];
        t.sda_in         = sda;
        return t;
    endfunction

    // command riding on a tick while the block is busy, should be ignored
    function automatic cmd_t noise_cmd();
        if ($urandom_range(0, 3) == 0)
            return cmd_t'(3'($urandom_range(1, 7)));
        return CMD_NONE;
    endfunction

    // offer one item, with random idle cycles ahead of it, and wait for the handshake
    task automatic offer(input in_item_t it);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_item  <= it;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        ticks_sent++;
    endtask

    // a whole command: the command tick, then enough ticks to finish it
    task automatic run_sequence(input cmd_t c);
        int further;
        int ack_delay;
        case (c) inside
            CMD_START, CMD_STOP:         further = 3;
            CMD_RECV_ACK, CMD_RECV_NACK: further = 20;
            default:                     further = 25;
        endcase
        offer(tick_of(c, 1'($urandom_range(0, 1))));
        repeat (further) offer(tick_of(noise_cmd(), 1'($urandom_range(0, 1))));
        if (further == 25) begin
            // acknowledge wait: usually short, now and then a slave that dawdles
            ack_delay = ($urandom_range(0, 29) == 0) ? $urandom_range(40, 60)
                                                     : $urandom_range(0, 3);
            repeat (ack_delay) offer(tick_of(noise_cmd(), 1'b1));
            offer(tick_of(noise_cmd(), 1'b0));
            offer(tick_of(noise_cmd(), 1'($urandom_range(0, 1))));
        end
    endtask

    // start, address, a few bytes either way, stop
    task automatic transfer();
        int   n;
        logic rd;
        n  = $urandom_range(1, 3);
        rd = 1'($urandom_range(0, 1));
        run_sequence(CMD_START);
        run_sequence(rd ? CMD_ADDR_READ : CMD_ADDR_WRITE);
        for (int i = 0; i < n; i++) begin
            if (rd)
                run_sequence((i == n - 1 || $urandom_range(0, 3) == 0) ? CMD_RECV_NACK
                                                                       : CMD_RECV_ACK);
            else
                run_sequence(CMD_SEND_DATA);
        end
        run_sequence(CMD_STOP);
        repeat ($urandom_range(0, 2)) offer(tick_of(CMD_NONE, 1'($urandom_range(0, 1))));
    endtask

    initial begin
        int target;
        int i;

        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed: idle ticks with the fields at both extremes, pins must hold
        offer('{cmd: CMD_NONE, data_byte: 8'h00, device_address: 7'h00, sda_in: 1'b0});
        offer('{cmd: CMD_NONE, data_byte: 8'hFF, device_address: 7'h7F, sda_in: 1'b1});
        // start, with stop commands arriving while busy that must be ignored
        offer(tick_of(CMD_START, 1'b1));
        repeat (3) offer(tick_of(CMD_STOP, 1'b0));
        // a clean stop, then a start straight after it
        run_sequence(CMD_STOP);
        run_sequence(CMD_START);
        offer(tick_of(CMD_NONE, 1'b1));

        for (i = 0; i < 4; i++) begin
            send_idle_pct   = idle_mix[i];
            drain_stall_pct = stall_mix[i];
            // pressure on the output side early in the no-idle phase
            if (i == 0)
                long_hold = 1'b1;
            target = ticks_sent + 365;
            while (ticks_sent < target) begin
                if ($urandom_range(0, 99) < 85) begin
                    transfer();
                end else begin
                    // broken traffic: random commands anywhere, then a run of
                    // plain ticks with sda low that brings any sequence to its end
                    repeat ($urandom_range(1, 12))
                        offer(tick_of(cmd_t'(3'($urandom_range(0, 7))),
                                      1'($urandom_range(0, 1))));
                    repeat (32) offer(tick_of(CMD_NONE, 1'b0));
                end
            end
        end

        // drain
        s_valid <= 1'b0;
        drain_stall_pct = 0;
        @(posedge aclk);
        while (waiting != 0) @(posedge aclk);
        repeat (10) @(posedge aclk);

        if (mismatches == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule
